/* rtl/r2fm_pkg.sv */
// Shared constants, payload types and twiddle tables for the radix-2 FFT magnitude core.
package r2fm_pkg;

  localparam int MAX_LOG2    = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int TW_BITS     = 16;
  localparam int TW_FRAC     = TW_BITS - 1;
  localparam int MAX_POINTS  = 1 << MAX_LOG2;
  localparam int HALF_POINTS = MAX_POINTS / 2;
  localparam int QUARTER_POINTS = MAX_POINTS / 4;
  localparam int STORE_BITS  = SAMPLE_BITS + MAX_LOG2 + 1;
  localparam int ADDR_BITS   = MAX_LOG2;
  localparam int TW_ADDR     = MAX_LOG2 - 1;
  localparam int MAG_BITS    = SAMPLE_BITS + MAX_LOG2;
  localparam int LOG2_BITS   = 4;
  localparam int ROOT_BITS   = STORE_BITS + 1;
  localparam int RAD_BITS    = 2 * ROOT_BITS;
  localparam int REM_BITS    = ROOT_BITS + 3;

  // Angle step between adjacent twiddle entries
  localparam real TW_STEP = 2.0 * 3.14159265358979323846 / real'(MAX_POINTS);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [MAG_BITS-1:0]  magnitude;
    logic [MAX_LOG2-1:0]  bin_index;
    logic                 last_bin;
  } out_t;

  typedef logic signed [TW_BITS-1:0] tw_rom_t [HALF_POINTS];

  // Quantize |v| to Q1.15, rounded to nearest and capped below 1.0
  function automatic logic signed [TW_BITS-1:0] tw_quant(real v);
    real    a;
    longint q;
    begin
      a = (v < 0.0) ? -v : v;
      q = longint'($floor(a * real'(1 << TW_FRAC) + 0.5));
      if (q > longint'((1 << TW_FRAC) - 1)) q = longint'((1 << TW_FRAC) - 1);
      tw_quant = TW_BITS'(q);
    end
  endfunction

  function automatic tw_rom_t build_cos();
    tw_rom_t t;
    real     ang;
    begin
      for (int k = 0; k < HALF_POINTS; k++) begin
        ang  = TW_STEP * real'(k);
        t[k] = (k > QUARTER_POINTS) ? -tw_quant($cos(ang)) : tw_quant($cos(ang));
      end
      build_cos = t;
    end
  endfunction

  function automatic tw_rom_t build_sin();
    tw_rom_t t;
    real     ang;
    begin
      for (int k = 0; k < HALF_POINTS; k++) begin
        ang  = TW_STEP * real'(k);
        t[k] = tw_quant($sin(ang));
      end
      build_sin = t;
    end
  endfunction

  localparam tw_rom_t TW_COS = build_cos();
  localparam tw_rom_t TW_SIN = build_sin();

endpackage

/* rtl/r2fm_ram.sv */
// Generic simple dual-port RAM with registered read data.
module r2fm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read in one clocked block
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/radix2_fft_magnitude_core.sv */
// Radix-2 DIT FFT magnitude core: load, transform in place, read out bin magnitudes.
// Load: one sample per cycle, unless the size register is being written, into the bit-reversed address of the store.
// Transform: N/2*log2(N) butterflies after the last sample, each reading u and v, multiplying, adding
//   and writing u and v back on the single store port pair; no input is taken meanwhile.
// Readout: each read runs abs, square, sum and a 28-step root, then waits for the output slot.
// Reset (synchronous, rst_n low): size 1024, loading phase, counts cleared, store unknown.
module radix2_fft_magnitude_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  r2fm_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output r2fm_pkg::out_t      out_data,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata
);

  localparam int AW = r2fm_pkg::ADDR_BITS;
  localparam int SW = r2fm_pkg::STORE_BITS;
  localparam int RW = r2fm_pkg::ROOT_BITS;
  localparam int LB = r2fm_pkg::LOG2_BITS;
  localparam int PW = SW + r2fm_pkg::TW_BITS;
  localparam int MB = r2fm_pkg::MAG_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_RDU, S_RDV, S_MUL, S_ADD, S_WRU, S_WRV,
    S_MRD, S_MSQ, S_MSUM, S_MROOT, S_MOUT
  } state_t;

  state_t               state_r;
  logic [LB-1:0]        log2_r;
  logic                 ready_r;
  logic [AW-1:0]        load_cnt_r, read_cnt_r;
  logic [LB-1:0]        stage_r;
  logic [AW-2:0]        bfly_r;
  logic [AW-1:0]        bin_r;

  logic signed [SW-1:0] ur_r, ui_r, vr_r, vi_r;
  logic signed [r2fm_pkg::TW_BITS-1:0] tc_r, ts_r;
  logic                 tz_r;
  logic signed [PW-1:0] p_cr_r, p_si_r, p_ci_r, p_sr_r;
  logic signed [SW-1:0] nu_r_r, nu_i_r, nv_r_r, nv_i_r;

  logic [SW-1:0]        ar_r, ai_r;
  logic [2*SW-1:0]      sq_r_r, sq_i_r;
  logic [r2fm_pkg::RAD_BITS-1:0] rad_r;
  logic [r2fm_pkg::REM_BITS-1:0] rem_r;
  logic [RW-1:0]        root_r;
  logic [4:0]           step_r;

  logic                 out_valid_r;
  r2fm_pkg::out_t       out_r;

  // Effective size
  logic [LB-1:0]        eff_log2;
  logic [AW-1:0]        n_m1;
  logic [AW-2:0]        half_m1_b;
  always_comb begin
    if (log2_r == '0) eff_log2 = LB'(1);
    else if (log2_r > LB'(r2fm_pkg::MAX_LOG2)) eff_log2 = LB'(r2fm_pkg::MAX_LOG2);
    else eff_log2 = log2_r;
    n_m1      = AW'((AW+1)'(1) << eff_log2) - AW'(1);
    half_m1_b = n_m1[AW-1:1];
  end

  // Bit-reversed load address
  logic [AW-1:0] brev_full, load_addr;
  always_comb begin
    for (int b = 0; b < AW; b++) brev_full[b] = load_cnt_r[AW-1-b];
    load_addr = brev_full >> (LB'(r2fm_pkg::MAX_LOG2) - eff_log2);
  end

  // Butterfly addresses and twiddle index
  logic [AW-1:0]             half, jm, u_addr, v_addr, bfly_w;
  logic [r2fm_pkg::TW_ADDR-1:0] tw_k;
  always_comb begin
    bfly_w = {1'b0, bfly_r};
    half   = AW'(1) << (stage_r - LB'(1));
    jm     = bfly_w & (half - AW'(1));
    u_addr = ((bfly_w >> (stage_r - LB'(1))) << stage_r) | jm;
    v_addr = u_addr + half;
    tw_k   = r2fm_pkg::TW_ADDR'(jm << (LB'(r2fm_pkg::MAX_LOG2) - stage_r));
  end

  // Store: {real, imag}
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [2*SW-1:0]     mem_wdata, mem_rdata;
  logic                in_xfer;

  // Refuse input while the size register is written
  assign in_ready = (state_r == S_IDLE) && !cfg_we;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = load_addr;
    mem_wdata = {SW'(in_data.sample), SW'(0)};
    mem_raddr = read_cnt_r;
    case (state_r)
      S_IDLE: begin
        mem_we = in_xfer && (in_data.op == r2fm_pkg::OP_LOAD) && !cfg_we;
      end
      S_RDU: mem_raddr = u_addr;
      S_RDV: mem_raddr = v_addr;
      S_WRU: begin
        mem_we    = 1'b1;
        mem_waddr = u_addr;
        mem_wdata = {nu_r_r, nu_i_r};
      end
      S_WRV: begin
        mem_we    = 1'b1;
        mem_waddr = v_addr;
        mem_wdata = {nv_r_r, nv_i_r};
      end
      default: ;
    endcase
  end

  r2fm_ram #(.WIDTH(2*SW), .DEPTH(r2fm_pkg::MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Butterfly arithmetic: round the products, add and subtract
  logic signed [SW:0]   rnd_cr, rnd_si, rnd_ci, rnd_sr;
  logic signed [SW+1:0] t_re, t_im;
  always_comb begin
    rnd_cr = (SW+1)'((p_cr_r + PW'(1 << (r2fm_pkg::TW_FRAC - 1))) >>> r2fm_pkg::TW_FRAC);
    rnd_si = (SW+1)'((p_si_r + PW'(1 << (r2fm_pkg::TW_FRAC - 1))) >>> r2fm_pkg::TW_FRAC);
    rnd_ci = (SW+1)'((p_ci_r + PW'(1 << (r2fm_pkg::TW_FRAC - 1))) >>> r2fm_pkg::TW_FRAC);
    rnd_sr = (SW+1)'((p_sr_r + PW'(1 << (r2fm_pkg::TW_FRAC - 1))) >>> r2fm_pkg::TW_FRAC);
    if (tz_r) begin
      t_re = (SW+2)'(vr_r);
      t_im = (SW+2)'(vi_r);
    end else begin
      t_re = (SW+2)'(rnd_cr) + (SW+2)'(rnd_si);
      t_im = (SW+2)'(rnd_ci) - (SW+2)'(rnd_sr);
    end
  end

  // Square root step on bit pairs
  logic [r2fm_pkg::REM_BITS-1:0] rem_sh, trial;
  logic                          take;
  always_comb begin
    rem_sh = {rem_r[r2fm_pkg::REM_BITS-3:0], rad_r[r2fm_pkg::RAD_BITS-1 -: 2]};
    trial  = r2fm_pkg::REM_BITS'({root_r, 2'b01});
    take   = (rem_sh >= trial);
  end

  logic [RW-1:0] mag_sat;
  assign mag_sat = (root_r > RW'(1 << (MB - 1))) ? RW'(1 << (MB - 1)) : root_r;

  // Load the output register when the result is done and the slot frees up
  logic out_load;
  assign out_load = (state_r == S_MOUT) && (!out_valid_r || out_ready);

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      log2_r      <= LB'(r2fm_pkg::MAX_LOG2);
      ready_r     <= 1'b0;
      load_cnt_r  <= '0;
      read_cnt_r  <= '0;
      stage_r     <= LB'(1);
      bfly_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once transferred
      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (cfg_we) begin
            log2_r     <= cfg_wdata;
            ready_r    <= 1'b0;
            load_cnt_r <= '0;
            read_cnt_r <= '0;
          end else if (in_xfer) begin
            if (in_data.op == r2fm_pkg::OP_LOAD) begin
              read_cnt_r <= '0;
              ready_r    <= 1'b0;
              if (ready_r) begin
                load_cnt_r <= AW'(1);
              end else if (load_cnt_r == n_m1) begin
                load_cnt_r <= '0;
                stage_r    <= LB'(1);
                bfly_r     <= '0;
                state_r    <= S_RDU;
              end else begin
                load_cnt_r <= load_cnt_r + AW'(1);
              end
              // a one-point-long frame is impossible, so a fresh frame never starts the FFT
            end else if (ready_r) begin
              bin_r   <= read_cnt_r;
              state_r <= S_MRD;
              if (read_cnt_r == n_m1) begin
                read_cnt_r <= '0;
                ready_r    <= 1'b0;
              end else begin
                read_cnt_r <= read_cnt_r + AW'(1);
              end
            end
          end
        end
        S_RDU: state_r <= S_RDV;
        S_RDV: begin
          ur_r    <= mem_rdata[2*SW-1:SW];
          ui_r    <= mem_rdata[SW-1:0];
          tc_r    <= r2fm_pkg::TW_COS[tw_k];
          ts_r    <= r2fm_pkg::TW_SIN[tw_k];
          tz_r    <= (jm == '0);
          state_r <= S_MUL;
        end
        S_MUL: begin
          vr_r    <= mem_rdata[2*SW-1:SW];
          vi_r    <= mem_rdata[SW-1:0];
          p_cr_r  <= PW'($signed(mem_rdata[2*SW-1:SW])) * PW'(tc_r);
          p_si_r  <= PW'($signed(mem_rdata[SW-1:0])) * PW'(ts_r);
          p_ci_r  <= PW'($signed(mem_rdata[SW-1:0])) * PW'(tc_r);
          p_sr_r  <= PW'($signed(mem_rdata[2*SW-1:SW])) * PW'(ts_r);
          state_r <= S_ADD;
        end
        S_ADD: begin
          nu_r_r  <= SW'((SW+2)'(ur_r) + t_re);
          nu_i_r  <= SW'((SW+2)'(ui_r) + t_im);
          nv_r_r  <= SW'((SW+2)'(ur_r) - t_re);
          nv_i_r  <= SW'((SW+2)'(ui_r) - t_im);
          state_r <= S_WRU;
        end
        S_WRU: state_r <= S_WRV;
        S_WRV: begin
          // advance butterfly, then stage
          if (bfly_r == half_m1_b) begin
            bfly_r <= '0;
            if (stage_r == eff_log2) begin
              ready_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              stage_r <= stage_r + LB'(1);
              state_r <= S_RDU;
            end
          end else begin
            bfly_r  <= bfly_r + (AW-1)'(1);
            state_r <= S_RDU;
          end
        end
        S_MRD: begin
          ar_r    <= mem_rdata[2*SW-1] ? -mem_rdata[2*SW-1:SW] : mem_rdata[2*SW-1:SW];
          ai_r    <= mem_rdata[SW-1] ? -mem_rdata[SW-1:0] : mem_rdata[SW-1:0];
          state_r <= S_MSQ;
        end
        S_MSQ: begin
          sq_r_r  <= (2*SW)'(ar_r) * (2*SW)'(ar_r);
          sq_i_r  <= (2*SW)'(ai_r) * (2*SW)'(ai_r);
          state_r <= S_MSUM;
        end
        S_MSUM: begin
          rad_r   <= r2fm_pkg::RAD_BITS'(sq_r_r) + r2fm_pkg::RAD_BITS'(sq_i_r);
          rem_r   <= '0;
          root_r  <= '0;
          step_r  <= 5'(RW - 1);
          state_r <= S_MROOT;
        end
        S_MROOT: begin
          rad_r  <= rad_r << 2;
          rem_r  <= take ? rem_sh - trial : rem_sh;
          root_r <= {root_r[RW-2:0], take};
          if (step_r == '0) state_r <= S_MOUT;
          else step_r <= step_r - 5'd1;
        end
        S_MOUT: begin
          // hold until the output slot is free
          if (out_load) begin
            out_valid_r        <= 1'b1;
            out_r.magnitude    <= mag_sat[MB-1:0];
            out_r.bin_index    <= bin_r;
            out_r.last_bin     <= (bin_r == n_m1);
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_mag_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.magnitude <= (MB)'(1 << (MB - 1))))
    else $error("magnitude above saturation limit");
  a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_bin) |-> (out_data.bin_index == n_m1))
    else $error("last bin flag on wrong bin");
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE || state_r == S_WRU || state_r == S_WRV))
    else $error("store written outside load or write-back");
  a_fft_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRV && bfly_r == half_m1_b && stage_r == eff_log2) |=> ready_r)
    else $error("spectrum not marked ready after last stage");
`endif

endmodule
